/* hdl/pl_pkg.sv */
`default_nettype none

package pl_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned OpW     = 2;
  localparam int unsigned PosW    = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 5;

  // Default list capacity.
  localparam int unsigned CapacityDef = 16;

  // Microprogram counter width and step addresses.
  localparam int unsigned UpcW = 3;
  localparam logic [UpcW-1:0] PcIdle     = 3'd0;
  localparam logic [UpcW-1:0] PcDispatch = 3'd1;
  localparam logic [UpcW-1:0] PcInsert   = 3'd2;
  localparam logic [UpcW-1:0] PcDelete   = 3'd3;
  localparam logic [UpcW-1:0] PcDump     = 3'd4;
  localparam logic [UpcW-1:0] PcNop      = 3'd5;
  localparam logic [UpcW-1:0] PcDumpLoop = 3'd6;

  // Operation codes of an input item.
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Status codes of a result item.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_BOUND = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Operation applied to the cell array in one step.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // Which result a step emits.
  typedef enum logic [2:0] {
    EMIT_NONE     = 3'd0,
    EMIT_INS      = 3'd1,
    EMIT_DEL      = 3'd2,
    EMIT_EMPTY_IF = 3'd3,
    EMIT_OK       = 3'd4,
    EMIT_ELEM     = 3'd5
  } emit_e;

  // Jump condition of a step.
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_NOT_START = 3'd1,
    COND_DISPATCH  = 3'd2,
    COND_NONEMPTY  = 3'd3,
    COND_MORE      = 3'd4
  } cond_e;

  // One microcode word.
  typedef struct packed {
    cell_op_e        cell_op;
    emit_e           emit;
    cond_e           cond;
    logic [UpcW-1:0] target;
    logic            ret;
    logic            load_rem;
  } ucw_t;

  // Command from the sequencer to the cell array.
  typedef struct packed {
    cell_op_e         op;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] value;
  } cell_cmd_t;

  // Microprogram ROM.
  function automatic ucw_t ucode_rom(input logic [UpcW-1:0] pc);
    ucw_t w;
    w = '{cell_op: CELL_HOLD, emit: EMIT_NONE, cond: COND_NEVER,
          target: PcIdle, ret: 1'b1, load_rem: 1'b0};
    case (pc)
      // Wait for an item; fall through to dispatch once one is taken.
      PcIdle: begin
        w.cond   = COND_NOT_START;
        w.target = PcIdle;
        w.ret    = 1'b0;
      end
      // Multiway jump on the opcode.
      PcDispatch: begin
        w.cond   = COND_DISPATCH;
        w.target = PcInsert;
      end
      PcInsert: begin
        w.cell_op = CELL_INSERT;
        w.emit    = EMIT_INS;
      end
      PcDelete: begin
        w.cell_op = CELL_DELETE;
        w.emit    = EMIT_DEL;
      end
      // An empty list reports at once; otherwise enter the dump loop.
      PcDump: begin
        w.emit     = EMIT_EMPTY_IF;
        w.cond     = COND_NONEMPTY;
        w.target   = PcDumpLoop;
        w.load_rem = 1'b1;
      end
      PcNop: begin
        w.emit = EMIT_OK;
      end
      // Emit the head cell and rotate the list by one place.
      PcDumpLoop: begin
        w.cell_op = CELL_ROTATE;
        w.emit    = EMIT_ELEM;
        w.cond    = COND_MORE;
        w.target  = PcDumpLoop;
      end
      default: begin
        w.ret = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/positional_list_insert_delete.sv */
`default_nettype none
// Steps: each item passes through the dispatch step and then its operation step; an insert,
// delete, unused opcode or empty dump gives its result from the operation step, and a nonempty
// dump then gives one element a cycle from the dump loop, one dump step per element. Results
// are registered. A new item is taken only once the sequencer is back in idle and busy is low.
// Reset clears the length and the sequencer; cell contents are not cleared.
// Results are shown for one cycle each; the receiver cannot stall them.

module positional_list_insert_delete
  import pl_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [OpW-1:0]     opcode_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [DataW-1:0]   value_i,
  output      logic               valid_o,
  output      logic [StatusW-1:0] status_o,
  output      logic [DataW-1:0]   element_o,
  output      logic [LenW-1:0]    length_o,
  output      logic               last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [UpcW-1:0]  pc_q, pc_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [OpW-1:0]   op_q;
  logic [PosW-1:0]  pos_q;
  logic [DataW-1:0] val_q;
  ucw_t             uw;
  logic             accept;
  logic             cond_true;
  logic             list_empty;
  logic [PosW-1:0]  count_ext;
  status_e          ins_st, del_st;
  cell_cmd_t        cmd;
  logic [DataW-1:0] head;

  logic               valid_d;
  status_e            status_d;
  logic [DataW-1:0]   element_d;
  logic               last_d;

  assign uw     = ucode_rom(pc_q);
  assign busy   = (pc_q != PcIdle);
  assign accept = start && !busy;

  // Latch the item when it is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  // Status of insert and delete from the stored length.
  assign list_empty = (count_q == '0);
  assign count_ext  = PosW'(count_q);

  always_comb begin
    if (list_empty) begin
      ins_st = ST_OK;
    end else if (pos_q > count_ext) begin
      ins_st = ST_BOUND;
    end else if (count_q == CntW'(CAPACITY)) begin
      ins_st = ST_FULL;
    end else begin
      ins_st = ST_OK;
    end

    if (list_empty) begin
      del_st = ST_EMPTY;
    end else if (pos_q >= count_ext) begin
      del_st = ST_BOUND;
    end else begin
      del_st = ST_OK;
    end
  end

  // Cell command, gated by the status of the operation.
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.pos   = list_empty ? '0 : pos_q;
    cmd.value = val_q;
    count_d   = count_q;
    case (uw.cell_op)
      CELL_INSERT: begin
        if (ins_st == ST_OK) begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      CELL_DELETE: begin
        if (del_st == ST_OK) begin
          cmd.op  = CELL_DELETE;
          count_d = count_q - 1'b1;
        end
      end
      CELL_ROTATE: begin
        cmd.op = CELL_ROTATE;
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  pl_cells #(
    .CAPACITY(CAPACITY)
  ) u_cells (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .count_i(count_q),
    .head_o (head)
  );

  // Next step: taken jump, return to idle, or the following step.
  always_comb begin
    case (uw.cond)
      COND_NOT_START: cond_true = !start;
      COND_DISPATCH:  cond_true = 1'b1;
      COND_NONEMPTY:  cond_true = !list_empty;
      COND_MORE:      cond_true = (rem_q != CntW'(1));
      default:        cond_true = 1'b0;
    endcase

    if (cond_true) begin
      pc_d = (uw.cond == COND_DISPATCH) ? uw.target + UpcW'(op_q) : uw.target;
    end else if (uw.ret) begin
      pc_d = PcIdle;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // Remaining elements of a dump.
  always_comb begin
    rem_d = rem_q;
    if (uw.load_rem) begin
      rem_d = count_q;
    end else if (uw.cell_op == CELL_ROTATE) begin
      rem_d = rem_q - 1'b1;
    end
  end

  // Result of the current step.
  always_comb begin
    valid_d   = 1'b0;
    status_d  = ST_OK;
    element_d = '0;
    last_d    = 1'b1;
    case (uw.emit)
      EMIT_INS: begin
        valid_d  = 1'b1;
        status_d = ins_st;
      end
      EMIT_DEL: begin
        valid_d  = 1'b1;
        status_d = del_st;
      end
      EMIT_EMPTY_IF: begin
        valid_d  = list_empty;
        status_d = ST_EMPTY;
      end
      EMIT_OK: begin
        valid_d = 1'b1;
      end
      EMIT_ELEM: begin
        valid_d   = 1'b1;
        element_d = head;
        last_d    = (rem_q == CntW'(1));
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PcIdle;
      count_q <= '0;
      rem_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      valid_o <= valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    status_o  <= status_d;
    element_o <= element_d;
    length_o  <= LenW'(count_d);
    last_o    <= last_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("list length above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("sequencer idle after taking an item");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result after the final result of an item");

  a_dump_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("dump stopped before its final element");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result without an item in progress");
`endif

endmodule

`default_nettype wire

/* hdl/pl_cells.sv */
`default_nettype none

module pl_cells
  import pl_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk_i,
  input  wire cell_cmd_t        cmd_i,
  input  wire logic [CntW-1:0]  count_i,
  output      logic [DataW-1:0] head_o
);

  logic [DataW-1:0] cells_q [CAPACITY];
  logic [DataW-1:0] cells_d [CAPACITY];

  // Cells read only neighbors, or the head on a rotate; all shift at once.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cells_d[i] = cells_q[i];
      case (cmd_i.op)
        CELL_INSERT: begin
          if (PosW'(i) == cmd_i.pos) begin
            cells_d[i] = cmd_i.value;
          end else if (PosW'(i) > cmd_i.pos) begin
            if (i > 0) begin
              cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
            end
          end
        end
        CELL_DELETE: begin
          if (PosW'(i) >= cmd_i.pos && i < CAPACITY - 1) begin
            cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        CELL_ROTATE: begin
          // The head element wraps to the last valid cell.
          if (CntW'(i + 1) == count_i) begin
            cells_d[i] = cells_q[0];
          end else if (i < CAPACITY - 1) begin
            cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        default: begin
          cells_d[i] = cells_q[i];
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      cells_q[i] <= cells_d[i];
    end
  end

  assign head_o = cells_q[0];

endmodule

`default_nettype wire

/* dv/tb_positional_list_insert_delete.sv */
`default_nettype none

module tb_positional_list_insert_delete;
  import pl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = CapacityDef;

  // One result item as seen on the output ports.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   element;
    logic [LenW-1:0]    len;
    logic               last;
  } list_result_t;

  // Shadow copy of the list and the queue of results it predicts.
  class list_scoreboard;
    logic [DataW-1:0] cells [Cap];
    int unsigned      n_stored;
    list_result_t     expected_q[$];
    int unsigned      errors;

    function new();
      n_stored = 0;
      errors   = 0;
    endfunction

    function void report_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void push_result(status_e st, logic [DataW-1:0] el, logic last);
      list_result_t r;
      r.status  = st;
      r.element = el;
      r.len     = n_stored[LenW-1:0];
      r.last    = last;
      expected_q.push_back(r);
    endfunction

    // Apply one accepted item to the shadow list and queue its results.
    function void note_item(op_e op, logic [PosW-1:0] pos, logic [DataW-1:0] val);
      status_e st;
      st = ST_OK;
      case (op)
        OP_INSERT: begin
          // An empty list takes the value at the head whatever the position.
          if (n_stored == 0) begin
            cells[0] = val;
            n_stored = 1;
          end else if (pos > n_stored) begin
            st = ST_BOUND;
          end else if (n_stored >= Cap) begin
            st = ST_FULL;
          end else begin
            for (int i = n_stored; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            n_stored++;
          end
          push_result(st, '0, 1'b1);
        end
        OP_DELETE: begin
          if (n_stored == 0) begin
            st = ST_EMPTY;
          end else if (pos >= n_stored) begin
            st = ST_BOUND;
          end else begin
            for (int i = pos; i + 1 < n_stored; i++) cells[i] = cells[i+1];
            n_stored--;
          end
          push_result(st, '0, 1'b1);
        end
        OP_DUMP: begin
          if (n_stored == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < n_stored; i++) begin
              push_result(ST_OK, cells[i], (i + 1 == n_stored));
            end
          end
        end
        default: begin
          push_result(ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report_error($sformatf("unexpected result: status %0d element %h length %0d last %0b",
                               got.status, got.element, got.len, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.element !== want.element ||
          got.len !== want.len || got.last !== want.last) begin
        report_error($sformatf({"result mismatch: expected status %0d element %h length %0d",
                                " last %0b, got status %0d element %h length %0d last %0b"},
                               want.status, want.element, want.len, want.last,
                               got.status, got.element, got.len, got.last));
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OpW-1:0]     opcode_i;
  logic [PosW-1:0]    position_i;
  logic [DataW-1:0]   value_i;
  logic               valid_o;
  logic [StatusW-1:0] status_o;
  logic [DataW-1:0]   element_o;
  logic [LenW-1:0]    length_o;
  logic               last_o;

  list_scoreboard sb;
  int unsigned    idle_pct;

  positional_list_insert_delete #(
    .CAPACITY(Cap)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .element_o  (element_o),
    .length_o   (length_o),
    .last_o     (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watch both sides at the rising edge: results first, then the item taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        sb.check_result('{status: status_o, element: element_o, len: length_o,
                          last: last_o});
      end
      if (start && !busy) begin
        sb.note_item(op_e'(opcode_i), position_i, value_i);
      end
    end
  end

  // Present one item, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_item(op_e op, logic [PosW-1:0] pos, logic [DataW-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start      <= 1'b1;
    opcode_i   <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Random item; growing phases favor inserts, shrinking phases favor deletes.
  task automatic random_item(bit grow);
    op_e             op;
    logic [PosW-1:0] pos;
    int unsigned     r;
    int unsigned     n;
    n = sb.n_stored;
    r = $urandom_range(99);
    if (r < 8) begin
      op = OP_DUMP;
    end else if (r < 11) begin
      op = OP_NONE;
    end else if (r < (grow ? 86 : 30)) begin
      op = OP_INSERT;
    end else begin
      op = OP_DELETE;
    end
    r = $urandom_range(99);
    if (r < 80) begin
      pos = PosW'($urandom_range(n));
    end else if (r < 90) begin
      pos = PosW'(n + $urandom_range(2, 1));
    end else begin
      pos = PosW'($urandom());
    end
    send_item(op, pos, $urandom());
  endtask

  // Main sequence.
  initial begin
    int unsigned pct_by_phase [3];
    pct_by_phase = '{7, 52, 0};
    sb         = new();
    idle_pct   = 0;
    start      = 1'b0;
    opcode_i   = OP_INSERT;
    position_i = '0;
    value_i    = '0;
    rst_ni     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty list: dump, delete, then an insert whose position is ignored.
    send_item(OP_DUMP, '0, '0);
    send_item(OP_DELETE, '0, '0);
    send_item(OP_INSERT, 16'hFFFF, 32'h7FFF_FFFF);
    // Insert past the end, at the end, at the head and in the middle.
    send_item(OP_INSERT, 16'd2, 32'h1234_5678);
    send_item(OP_INSERT, 16'd1, 32'h8000_0000);
    send_item(OP_INSERT, 16'd0, 32'h0000_0000);
    send_item(OP_INSERT, 16'd1, 32'hFFFF_FFFF);
    send_item(OP_DUMP, '0, '0);
    // Delete past the end, then the last element and the head.
    send_item(OP_DELETE, 16'd4, '0);
    send_item(OP_DELETE, 16'hFFFF, '0);
    send_item(OP_DELETE, 16'd3, '0);
    send_item(OP_DELETE, 16'd0, '0);
    send_item(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    // Fill to capacity, then hit the full and the bound checks on a full list.
    while (sb.n_stored < Cap) begin
      send_item(OP_INSERT, PosW'($urandom_range(sb.n_stored)), $urandom());
    end
    send_item(OP_INSERT, PosW'(Cap), 32'h5A5A_5A5A);
    send_item(OP_INSERT, PosW'(Cap + 1), 32'hA5A5_A5A5);
    send_item(OP_DUMP, '0, '0);
    send_item(OP_DELETE, PosW'(Cap - 1), '0);
    drain();

    // Random part in three idling phases, each one growing and one shrinking stretch.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = pct_by_phase[phase];
      for (int k = 0; k < 72; k++) begin
        random_item(k < 36);
        if ($urandom_range(99) < 3) begin
          drain();
        end
      end
      drain();
    end

    repeat (24) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_positional_list_insert_delete: clean");
    end else begin
      $display("tb_positional_list_insert_delete: errors");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #2_000_000;
    $display("tb_positional_list_insert_delete: errors");
    $finish;
  end

endmodule

`default_nettype wire
